// ===== rtl/core/cas_pkg.sv =====
// Shared constants and codes for the clock aging slot allocator.
`default_nettype none

package cas_pkg;

    // Slot store geometry
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = 10;
    localparam int AGE_W  = 11;
    localparam int PASS_W = 3;
    localparam int ROW_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_AGE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREED_AGE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASSES    = 2'd3;

    // Register values after reset
    localparam logic [AGE_W-1:0]  FRESH_AGE_RST      = 11'd1000;
    localparam logic [AGE_W-1:0]  KEEP_THRESHOLD_RST = 11'd500;
    localparam logic [AGE_W-1:0]  FREED_AGE_RST      = 11'd2;
    localparam logic [PASS_W-1:0] MAX_PASSES_RST     = 3'd3;
    localparam logic [ROW_W-1:0]  ROW_NUMBER_RST     = 32'd1;

    // Command codes carried in the input tuser
    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_FREE     = 1'b1;

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

endpackage

`default_nettype wire

// ===== rtl/core/cas_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module cas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/clock_aging_slot_allocator.sv =====
// Top level of the clock aging slot allocator.
//
// Items arrive on the s_ channel: tuser carries the command (allocate or free)
// and tdata the slot to free. Each item yields exactly one result item on the
// m_ channel: tuser is the granted flag, tdata holds the slot and row number.
// A free writes the freed age into the slot when it is accepted and goes
// straight to the done state. An allocate walks the clock hand one slot at a
// time; each slot visited passes through a read state, which reads the used
// and age stores, and an evaluate state, which decides and writes the new age
// back, for at most max_passes * 1024 slots in the worst case, or a single
// slot when max_passes is zero.
// Items are processed one at a time; a new item is taken once the previous
// one has finished and its result has moved into the output register, even
// while it still waits there. When the receiver stalls, the result holds in
// the output register and a second finished result holds inside until the
// register drains. After reset the block runs a clearing pass over all 1024
// slots of both stores and takes no item until it is done; configuration
// writes are taken at any time and the registers come up with their defaults.
`default_nettype none

module clock_aging_slot_allocator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [cas_pkg::IN_TDATA_W-1:0]     s_tdata,   // [9:0] slot_index
    input  wire logic                               s_tuser,   // [0] command
    // Output channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [cas_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [9:0] granted_slot, [41:10] row_number
    output logic                                    m_tuser,   // [0] granted
    // Configuration port
    input  wire logic                               cfg_we,
    input  wire logic [cas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cas_pkg::CFG_W-1:0]          cfg_data
);

    import cas_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [AGE_W-1:0]  fresh_age_reg, fresh_age_next;
    logic [AGE_W-1:0]  keep_threshold_reg, keep_threshold_next;
    logic [AGE_W-1:0]  freed_age_reg, freed_age_next;
    logic [PASS_W-1:0] max_passes_reg, max_passes_next;

    logic [SLOT_W-1:0] hand_reg, hand_next;
    logic [PASS_W-1:0] passes_reg, passes_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;

    // Result held until the output register is free
    logic              res_granted_reg, res_granted_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [ROW_W-1:0]  res_row_reg, res_row_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              out_granted_reg, out_granted_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    // Store ports
    logic              used_we, used_wdata, used_rdata;
    logic              age_we;
    logic [AGE_W-1:0]  age_wdata, age_rdata;
    logic [SLOT_W-1:0] mem_waddr;
    logic              mem_re;

    logic              in_accept;
    logic              out_free;
    logic [SLOT_W-1:0] hand_inc;
    logic              qualifies;
    logic [AGE_W-1:0]  age_dec;
    logic [AGE_W-1:0]  age_kept;
    logic [SLOT_W-1:0] in_slot;

    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // The hand steps to the next slot and wraps after the last one
    assign hand_inc = (hand_reg == SLOT_W'(SLOTS - 1)) ? '0 : hand_reg + 1'b1;

    // Decision on the slot just read
    assign qualifies = !used_rdata || (age_rdata == '0);
    assign age_dec   = age_rdata - 1'b1;
    assign age_kept  = (age_dec > keep_threshold_reg) ? fresh_age_reg : age_dec;

    // Store ports. Writes in the evaluate cycle hit the slot under the hand,
    // while the following read is of the next slot, so the two never collide.
    always_comb
    begin
        used_we    = 1'b0;
        used_wdata = 1'b0;
        age_we     = 1'b0;
        age_wdata  = '0;
        mem_waddr  = hand_reg;
        mem_re     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                used_we   = 1'b1;
                age_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == CMD_FREE))
                begin
                    age_we    = 1'b1;
                    age_wdata = freed_age_reg;
                    mem_waddr = in_slot;
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_EVAL:
            begin
                age_we = 1'b1;
                if (qualifies)
                begin
                    used_we    = 1'b1;
                    used_wdata = 1'b1;
                    age_wdata  = fresh_age_reg;
                end
                else
                begin
                    age_wdata = age_kept;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Next state and register values
    always_comb
    begin
        state_next          = state_reg;
        fresh_age_next      = fresh_age_reg;
        keep_threshold_next = keep_threshold_reg;
        freed_age_next      = freed_age_reg;
        max_passes_next     = max_passes_reg;
        hand_next           = hand_reg;
        passes_next         = passes_reg;
        row_next            = row_reg;
        clr_next            = clr_reg;
        res_granted_next    = res_granted_reg;
        res_slot_next       = res_slot_reg;
        res_row_next        = res_row_reg;
        out_valid_next      = out_valid_reg && !m_tready;
        out_granted_next    = out_granted_reg;
        out_slot_next       = out_slot_reg;
        out_row_next        = out_row_reg;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRESH_AGE:      fresh_age_next      = cfg_data[AGE_W-1:0];
                CFG_KEEP_THRESHOLD: keep_threshold_next = cfg_data[AGE_W-1:0];
                CFG_FREED_AGE:      freed_age_next      = cfg_data[AGE_W-1:0];
                CFG_MAX_PASSES:     max_passes_next     = cfg_data[PASS_W-1:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == CMD_FREE)
                    begin
                        // Every 10-bit index names a slot, so a free always succeeds
                        res_granted_next = 1'b1;
                        res_slot_next    = in_slot;
                        res_row_next     = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        passes_next = '0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                hand_next = hand_inc;
                if (hand_inc == '0)
                begin
                    passes_next = passes_reg + 1'b1;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (qualifies)
                begin
                    res_granted_next = 1'b1;
                    res_slot_next    = hand_reg;
                    res_row_next     = row_reg;
                    row_next         = row_reg + 1'b1;
                    state_next       = ST_DONE;
                end
                else if (passes_reg >= max_passes_reg)
                begin
                    res_granted_next = 1'b0;
                    res_slot_next    = '0;
                    res_row_next     = '0;
                    state_next       = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_slot_next    = res_slot_reg;
                    out_row_next     = res_row_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            fresh_age_reg      <= FRESH_AGE_RST;
            keep_threshold_reg <= KEEP_THRESHOLD_RST;
            freed_age_reg      <= FREED_AGE_RST;
            max_passes_reg     <= MAX_PASSES_RST;
            hand_reg           <= '0;
            passes_reg         <= '0;
            row_reg            <= ROW_NUMBER_RST;
            clr_reg            <= '0;
            res_granted_reg    <= 1'b0;
            res_slot_reg       <= '0;
            res_row_reg        <= '0;
            out_valid_reg      <= 1'b0;
            out_granted_reg    <= 1'b0;
            out_slot_reg       <= '0;
            out_row_reg        <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            fresh_age_reg      <= fresh_age_next;
            keep_threshold_reg <= keep_threshold_next;
            freed_age_reg      <= freed_age_next;
            max_passes_reg     <= max_passes_next;
            hand_reg           <= hand_next;
            passes_reg         <= passes_next;
            row_reg            <= row_next;
            clr_reg            <= clr_next;
            res_granted_reg    <= res_granted_next;
            res_slot_reg       <= res_slot_next;
            res_row_reg        <= res_row_next;
            out_valid_reg      <= out_valid_next;
            out_granted_reg    <= out_granted_next;
            out_slot_reg       <= out_slot_next;
            out_row_reg        <= out_row_next;
        end
    end

    // Used flags and ages, one entry per slot
    cas_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (mem_waddr),
        .wdata (used_wdata),
        .re    (mem_re),
        .raddr (hand_inc),
        .rdata (used_rdata)
    );

    cas_ram #(
        .WIDTH (AGE_W),
        .DEPTH (SLOTS)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (mem_waddr),
        .wdata (age_wdata),
        .re    (mem_re),
        .raddr (hand_inc),
        .rdata (age_rdata)
    );

    // Output channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ROW_W - SLOT_W){1'b0}}, out_row_reg, out_slot_reg};

    // A result only appears after the block has finished an item
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

    // The row sequence only ever steps by one
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg != $past(row_reg)) |-> (row_reg == $past(row_reg) + 1'b1))
        else $error("row number skipped");

    // The evaluate cycle always works on the slot that was just read
    a_hand_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_EVAL && hand_reg == $past(hand_inc)))
        else $error("hand does not match the slot read");

    // No item is taken and no result shown while the stores are being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s_tready && !out_valid_reg))
        else $error("activity during the clearing pass");

endmodule

`default_nettype wire

// ===== tb/sv/cas_tb_pkg.sv =====
// Slot grant tracker: predicts and checks each result of the clock aging slot allocator.
`timescale 1ns / 100ps

package cas_tb_pkg;

    import cas_pkg::*;

    // One expected result item
    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row;
    } slot_grant_t;

    class slot_grant_tracker;

        // Mirror of the block's slot stores, hand and sequence counter
        logic              used [SLOTS];
        logic [AGE_W-1:0]  age  [SLOTS];
        logic [SLOT_W-1:0] hand;
        logic [ROW_W-1:0]  next_row;

        // Mirror of the configuration registers
        logic [AGE_W-1:0]  fresh_age;
        logic [AGE_W-1:0]  keep_threshold;
        logic [AGE_W-1:0]  freed_age;
        logic [PASS_W-1:0] max_passes;

        slot_grant_t pending_grants[$];

        int errors;
        int requests;
        int grants;
        int refusals;
        int frees;
        int hand_wraps;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
                age[i]  = '0;
            end
            hand           = '0;
            next_row       = ROW_NUMBER_RST;
            fresh_age      = FRESH_AGE_RST;
            keep_threshold = KEEP_THRESHOLD_RST;
            freed_age      = FREED_AGE_RST;
            max_passes     = MAX_PASSES_RST;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_FRESH_AGE:      fresh_age      = value[AGE_W-1:0];
                CFG_KEEP_THRESHOLD: keep_threshold = value[AGE_W-1:0];
                CFG_FREED_AGE:      freed_age      = value[AGE_W-1:0];
                CFG_MAX_PASSES:     max_passes     = value[PASS_W-1:0];
                default: ;
            endcase
        endfunction

        // Walk the hand until a slot qualifies or the pass budget runs out.
        // At least one slot is always visited, even with a budget of zero.
        function slot_grant_t sweep_for_slot();
            slot_grant_t g;
            int          passes;
            g      = '0;
            passes = 0;
            do
            begin
                hand = SLOT_W'((int'(hand) + 1) % SLOTS);
                if (hand == '0)
                begin
                    passes++;
                    hand_wraps++;
                end
                if (!used[hand] || age[hand] == '0)
                begin
                    used[hand] = 1'b1;
                    age[hand]  = fresh_age;
                    g.granted  = 1'b1;
                    g.slot     = hand;
                    g.row      = next_row;
                    next_row   = next_row + 1'b1;
                    grants++;
                    return g;
                end
                age[hand] = age[hand] - 1'b1;
                if (age[hand] > keep_threshold)
                    age[hand] = fresh_age;
            end
            while (passes < int'(max_passes));
            refusals++;
            return g;
        endfunction

        // Called for every accepted input item.
        function void note_request(logic cmd, logic [SLOT_W-1:0] idx);
            slot_grant_t g;
            requests++;
            if (cmd == CMD_FREE)
            begin
                // A free only rewrites the age; the used flag is left alone.
                age[idx]  = freed_age;
                g.granted = 1'b1;
                g.slot    = idx;
                g.row     = '0;
                frees++;
            end
            else
                g = sweep_for_slot();
            pending_grants.push_back(g);
        endfunction

        // Called for every accepted result item.
        function void check_grant(logic granted, logic [SLOT_W-1:0] slot,
                                  logic [ROW_W-1:0] row);
            slot_grant_t want;
            if (pending_grants.size() == 0)
            begin
                $error("result with no request outstanding: granted %0d slot %0d row %0d",
                       granted, slot, row);
                errors++;
                return;
            end
            want = pending_grants.pop_front();
            if (granted !== want.granted)
            begin
                $error("granted mismatch: expected %0d, actual %0d", want.granted, granted);
                errors++;
            end
            if (slot !== want.slot)
            begin
                $error("granted_slot mismatch: expected %0d, actual %0d", want.slot, slot);
                errors++;
            end
            if (row !== want.row)
            begin
                $error("row_number mismatch: expected %0d, actual %0d", want.row, row);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_clock_aging_slot_allocator.sv =====
// Top-level testbench of the clock aging slot allocator: stimulus, idling and result checking.
`timescale 1ns / 100ps

module tb_clock_aging_slot_allocator;

    import cas_pkg::*;
    import cas_tb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [9:0] slot_index
    logic                   s_tuser;    // [0] command
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [9:0] granted_slot, [41:10] row_number
    logic                   m_tuser;    // [0] granted
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    slot_grant_tracker sb = new();

    // Set while both sides must run without idling.
    bit steady       = 1'b0;
    // Asks the result side for one long hold-off.
    bit hold_off_req = 1'b0;
    int settings_run = 1;

    clock_aging_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check every result item as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_grant(m_tuser, m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: ROW_W]);
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= 10);
                @(posedge clk);
            end
        end
    end

    // Offer one item and wait until it is taken, then maybe leave a gap.
    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] idx);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_TDATA_W'(idx);
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, idx);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic program_regs(input int fresh, input int keep, input int freed,
                                input int passes);
        settle();
        cfg_write(CFG_FRESH_AGE, CFG_W'(fresh));
        cfg_write(CFG_KEEP_THRESHOLD, CFG_W'(keep));
        cfg_write(CFG_FREED_AGE, CFG_W'(freed));
        cfg_write(CFG_MAX_PASSES, CFG_W'(passes));
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Random mix of allocates and frees. Frees favour slots just ahead of
    // the hand so that freed slots come round again soon.
    task automatic run_phase(input int count, input int alloc_pct);
        logic              cmd;
        logic [SLOT_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOCATE : CMD_FREE;
            case ($urandom_range(0, 9))
                0:       idx = '0;
                1:       idx = '1;
                2, 3:    idx = sb.hand + SLOT_W'($urandom_range(1, 16));
                default: idx = SLOT_W'($urandom());
            endcase
            send_request(cmd, idx);
        end
    endtask

    initial
    begin : stimulus
        int chunks;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_ALLOCATE;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FRESH_AGE;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: slot extremes, frees of never used and used slots,
        // alternating bit patterns, allocates from a clean store.
        send_request(CMD_FREE, '0);
        send_request(CMD_FREE, '1);
        send_request(CMD_ALLOCATE, '0);
        send_request(CMD_ALLOCATE, '1);
        send_request(CMD_FREE, SLOT_W'(1));
        send_request(CMD_FREE, 10'h2AA);
        send_request(CMD_FREE, 10'h155);
        send_request(CMD_FREE, SLOT_W'(5));
        send_request(CMD_ALLOCATE, 10'h155);
        send_request(CMD_ALLOCATE, '0);
        send_request(CMD_ALLOCATE, '0);
        send_request(CMD_ALLOCATE, '0);

        // Default settings while the store is still filling.
        run_phase(80, 90);

        // Largest fresh age, refresh everything, widest pass budget.
        program_regs(2047, 0, 2047, 7);
        run_phase(30, 90);

        // Short ages that decay freely; fill the store until the hand wraps.
        program_regs(1, 2047, 0, 2);
        run_phase(500, 92);
        chunks = 0;
        while (sb.hand_wraps == 0 && chunks < 10)
        begin
            run_phase(100, 92);
            chunks++;
        end
        run_phase(100, 80);

        // Threshold one below the fresh age, with no idling on either side.
        program_regs(5, 4, 2047, 7);
        steady = 1'b1;
        run_phase(120, 65);
        steady = 1'b0;

        // Fresh age of zero; the result side holds off long enough to back up the input.
        program_regs(0, 700, 1, 1);
        hold_off_req = 1'b1;
        run_phase(80, 65);

        // Pass budget of zero: each allocate looks at a single slot.
        program_regs(3, 3, 2, 0);
        run_phase(80, 70);

        // Active slots never age out, so most allocates fail after one pass.
        program_regs(2047, 0, 1, 1);
        run_phase(40, 70);

        settle();
        repeat (20) @(posedge clk);

        $display("Covered %0d items: %0d grants, %0d failed allocates, %0d frees",
                 sb.requests, sb.grants, sb.refusals, sb.frees);
        $display("Hand wrapped %0d times across %0d register settings",
                 sb.hand_wraps, settings_run);
        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Give up well beyond the slowest legal run.
    initial
    begin : watchdog
        #(64'd600_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
